// File: hw/rtl/cfe_pkg.sv
// Package for the continued-fraction expander.
// Holds the sequencer state type, the term limit and the divider status word.
// No dependencies.
package cfe_pkg;

    localparam int MAX_TERMS = 48;
    localparam int CNT_W     = $clog2(MAX_TERMS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_stat;

endpackage

// File: hw/rtl/cfe_ifs.sv
// Valid/ready channel interfaces for the continued-fraction expander.
// cfe_in_if carries the rational number, cfe_out_if one term word.
// No dependencies.
interface cfe_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] numerator;
    logic        [DATA_WIDTH-2:0] denominator;

    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface cfe_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] term;
    logic                         last_term;
    logic                         div_error;

    modport source (output valid, output term, output last_term, output div_error, input ready);
    modport sink   (input valid, input term, input last_term, input div_error, output ready);
endinterface

// File: hw/rtl/cfe_divider.sv
// Iterative signed divider, truncating toward zero, one quotient bit a cycle.
// Restoring division on magnitudes, signs applied at the output.
// Depends on cfe_pkg.
module cfe_divider #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_dividend,
    input  logic signed [DATA_WIDTH-1:0] i_divisor,
    output logic signed [DATA_WIDTH-1:0] o_quotient,
    output logic signed [DATA_WIDTH-1:0] o_remainder,
    output cfe_pkg::t_div_stat           o_stat
);
    import cfe_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem, r_quo, r_dvs;
    logic          r_neg_q, r_neg_r;

    logic [W-1:0]  shifted;
    logic [W:0]    diff;
    logic [W-1:0]  a_mag, b_mag;

    assign shifted = {r_rem[W-2:0], r_quo[W-1]};
    assign diff    = {1'b0, shifted} - {1'b0, r_dvs};
    assign a_mag   = i_dividend[W-1] ? W'(-i_dividend) : W'(i_dividend);
    assign b_mag   = i_divisor[W-1]  ? W'(-i_divisor)  : W'(i_divisor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_quo   <= a_mag;
            r_dvs   <= b_mag;
            r_neg_q <= i_dividend[W-1] ^ i_divisor[W-1];
            r_neg_r <= i_dividend[W-1];
        end else if (r_busy) begin
            r_rem <= diff[W] ? shifted : diff[W-1:0];
            r_quo <= {r_quo[W-2:0], ~diff[W]};
        end
    end

    assign o_quotient    = r_neg_q ? signed'(-r_quo) : signed'(r_quo);
    assign o_remainder   = r_neg_r ? signed'(-r_rem) : signed'(r_rem);
    assign o_stat.done     = r_done;
    assign o_stat.rem_zero = (r_rem == '0);

endmodule

// File: hw/rtl/continued_fraction_expander.sv
// Continued-fraction expander: takes numerator/denominator and emits the partial
// quotients of its continued fraction, each one a quotient truncated toward zero,
// one word per term, the final one marked with last_term; a zero denominator gives
// a single word with div_error set and term 0. One shared bit-serial divider does
// all the work: each term goes through start, DATA_WIDTH divide steps, done and
// output, and can be held by an output stall. At most 48 terms are emitted. The
// input is not ready until the last term word has been taken.
// Depends on cfe_pkg, cfe_ifs and cfe_divider.
module continued_fraction_expander #(
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cfe_in_if.sink    i_in,
    cfe_out_if.source o_out
);
    import cfe_pkg::*;

    localparam int W = DATA_WIDTH;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_start, n_start;
    logic signed [W-1:0] r_a, r_b, r_term;
    logic               r_last, r_err;

    logic signed [W-1:0] quotient, remainder;
    t_div_stat           s_div;

    logic in_acc, out_acc;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    cfe_divider #(.DATA_WIDTH(W)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_start),
        .i_dividend  (r_a),
        .i_divisor   (r_b),
        .o_quotient  (quotient),
        .o_remainder (remainder),
        .o_stat      (s_div)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_count = '0;
                    if (i_in.denominator == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_DIV;
                        n_start = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (s_div.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_acc) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_DIV;
                        n_start = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_start <= 1'b0;
            r_last  <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_start <= n_start;
            if (r_state == S_IDLE && in_acc) begin
                r_last <= (i_in.denominator == '0);
                r_err  <= (i_in.denominator == '0);
            end else if (r_state == S_DIV && s_div.done) begin
                r_last <= s_div.rem_zero || (r_count == CNT_W'(MAX_TERMS - 1));
                r_err  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_a    <= i_in.numerator;
            r_b    <= signed'({1'b0, i_in.denominator});
            r_term <= '0;
        end else if (r_state == S_DIV && s_div.done) begin
            r_term <= quotient;
            r_a    <= r_b;
            r_b    <= remainder;
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = (r_state == S_OUT);
    assign o_out.term      = r_term;
    assign o_out.last_term = r_last;
    assign o_out.div_error = r_err;

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.div_error |-> o_out.last_term && o_out.term == '0)
        else $error("error word without last_term or with nonzero term");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_div.done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_start_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.denominator != '0 |=> r_start && r_state == S_DIV)
        else $error("accepted word did not start a division");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && r_count == CNT_W'(MAX_TERMS - 1) |-> o_out.last_term)
        else $error("term limit reached without last_term");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench for continued_fraction_expander: drives numerator/denominator words and checks
// every term word against a Euclidean expansion worked out locally, with random idling.
// Depends on cfe_pkg, cfe_ifs and the continued_fraction_expander RTL.
module testbench;
    import cfe_pkg::*;

    localparam int DW = 32;
    localparam int NW = DW - 1;

    typedef struct {
        logic signed [DW-1:0] term;
        logic                 last_term;
        logic                 div_error;
    } t_term_word;

    typedef struct {
        logic signed [DW-1:0] num;
        logic        [DW-2:0] den;
        bit                   typed;
        logic signed [DW-1:0] term;
        logic                 last_term;
        logic                 div_error;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cfe_in_if  #(.DATA_WIDTH(DW)) in_ch ();
    cfe_out_if #(.DATA_WIDTH(DW)) out_ch ();

    continued_fraction_expander #(.DATA_WIDTH(DW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_term_word pending_terms[$];
    int         mismatches = 0;
    bit         quiet      = 1'b0;

    // typed rows carry their single expected word; the rest go through the predictor
    t_stim_row directed_rows[21] = '{
        '{32'sh0000_0000, 31'h0000_0000, 1'b1, 32'sh0000_0000,   1'b1, 1'b1},
        '{32'sh7FFF_FFFF, 31'h0000_0000, 1'b1, 32'sh0000_0000,   1'b1, 1'b1},
        '{32'sh8000_0000, 31'h0000_0000, 1'b1, 32'sh0000_0000,   1'b1, 1'b1},
        '{32'shFFFF_FFFF, 31'h0000_0000, 1'b1, 32'sh0000_0000,   1'b1, 1'b1},
        '{32'sh0000_0000, 31'h0000_0001, 1'b1, 32'sh0000_0000,   1'b1, 1'b0},
        '{32'sh7FFF_FFFF, 31'h0000_0001, 1'b1, 32'sh7FFF_FFFF,   1'b1, 1'b0},
        '{32'sh8000_0000, 31'h0000_0001, 1'b1, 32'sh8000_0000,   1'b1, 1'b0},
        '{32'shFFFF_FFFF, 31'h0000_0001, 1'b1, 32'shFFFF_FFFF,   1'b1, 1'b0},
        '{32'sh0000_0000, 31'h7FFF_FFFF, 1'b1, 32'sh0000_0000,   1'b1, 1'b0},
        '{32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 32'sh0000_0001,   1'b1, 1'b0},
        '{32'sh8000_0000, 31'h0000_0002, 1'b1, 32'shC000_0000,   1'b1, 1'b0},
        '{32'sh8000_0000, 31'h7FFF_FFFF, 1'b0, 32'sh0,           1'b0, 1'b0},
        '{32'sh0000_0001, 31'h7FFF_FFFF, 1'b0, 32'sh0,           1'b0, 1'b0},
        '{-32'sd7,        31'd3,         1'b0, 32'sh0,           1'b0, 1'b0},
        '{32'sd7,         31'd3,         1'b0, 32'sh0,           1'b0, 1'b0},
        '{32'sd355,       31'd113,       1'b0, 32'sh0,           1'b0, 1'b0},
        '{32'sd1836311903, 31'd1134903170, 1'b0, 32'sh0,         1'b0, 1'b0},
        '{-32'sd1836311903, 31'd1134903170, 1'b0, 32'sh0,        1'b0, 1'b0},
        '{-32'sd1,        31'd2,         1'b0, 32'sh0,           1'b0, 1'b0},
        '{32'sh7FFF_FFFF, 31'h7FFF_FFFE, 1'b0, 32'sh0,           1'b0, 1'b0},
        '{32'sh5555_AAAA, 31'h2AAA_5555, 1'b0, 32'sh0,           1'b0, 1'b0}
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 60);
    endfunction

    function automatic void expand_fraction(logic signed [DW-1:0] num, logic [DW-2:0] den);
        longint     dividend;
        longint     divisor;
        longint     q;
        longint     r;
        int         count;
        t_term_word w;
        dividend = longint'(num);
        divisor  = longint'(den);
        if (divisor == 0) begin
            w.term      = '0;
            w.last_term = 1'b1;
            w.div_error = 1'b1;
            pending_terms.push_back(w);
            return;
        end
        count = 0;
        do begin
            q           = dividend / divisor;
            r           = dividend % divisor;
            w.term      = q[DW-1:0];
            w.last_term = (r == 0) || (count + 1 >= MAX_TERMS);
            w.div_error = 1'b0;
            pending_terms.push_back(w);
            count++;
            dividend = divisor;
            divisor  = r;
        end while (!w.last_term);
    endfunction

    task automatic send_fraction(input logic signed [DW-1:0] num, input logic [DW-2:0] den);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.numerator   <= num;
        in_ch.denominator <= den;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic check_word();
        t_term_word want;
        if (pending_terms.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected term word: term %0d last %0b err %0b",
                         out_ch.term, out_ch.last_term, out_ch.div_error);
            return;
        end
        want = pending_terms.pop_front();
        if (out_ch.term !== want.term || out_ch.last_term !== want.last_term ||
            out_ch.div_error !== want.div_error) begin
            mismatches++;
            if (mismatches <= 10)
                $display("term word mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                         want.term, want.last_term, want.div_error,
                         out_ch.term, out_ch.last_term, out_ch.div_error);
        end
    endtask

    initial begin
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                check_word();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                stall = pick_gap();
                out_ch.ready <= (stall == 0);
                if (stall > 0) stall--;
            end
        end
    end

    initial begin
        logic signed [DW-1:0] num;
        logic        [DW-2:0] den;
        int                   pick;
        int                   k;
        longint               q;
        longint               fib[47];
        t_term_word           w;

        fib[0] = 0;
        fib[1] = 1;
        for (int i = 2; i < 47; i++) fib[i] = fib[i-1] + fib[i-2];

        in_ch.valid       <= 1'b0;
        in_ch.numerator   <= '0;
        in_ch.denominator <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_fraction(directed_rows[i].num, directed_rows[i].den);
            if (directed_rows[i].typed) begin
                w.term      = directed_rows[i].term;
                w.last_term = directed_rows[i].last_term;
                w.div_error = directed_rows[i].div_error;
                pending_terms.push_back(w);
            end else begin
                expand_fraction(directed_rows[i].num, directed_rows[i].den);
            end
        end

        for (int n = 0; n < 370; n++) begin
            if ($urandom_range(29) == 0) quiet = !quiet;
            pick = $urandom_range(19);
            num  = $urandom;
            den  = NW'($urandom_range(32'h7FFF_FFFF));
            case (pick)
                8, 9, 10: den = NW'($urandom_range(1, 255));
                11, 12: begin
                    num = $urandom_range(2000) - 1000;
                    den = NW'($urandom_range(1, 1000));
                end
                13, 14: begin
                    k   = $urandom_range(1, 45);
                    q   = $urandom_range(1) ? -fib[k+1] : fib[k+1];
                    num = q[DW-1:0];
                    den = fib[k][DW-2:0];
                end
                15: den = '0;
                16, 17: begin
                    case ($urandom_range(4))
                        0: num = 32'sh8000_0000;
                        1: num = 32'sh7FFF_FFFF;
                        2: num = -32'sd1;
                        3: num = '0;
                        default: num = 32'sd1;
                    endcase
                    if ($urandom_range(1)) den = 31'h7FFF_FFFF;
                end
                18, 19: begin
                    den = NW'($urandom_range(1, 65535));
                    q   = (longint'($urandom_range(32767)) - 16384) * longint'(den);
                    num = q[DW-1:0];
                end
                default: ;
            endcase
            send_fraction(num, den);
            expand_fraction(num, den);
        end
        in_ch.valid <= 1'b0;

        while (pending_terms.size() != 0) @(posedge i_clk);
        repeat (4 * DW) @(posedge i_clk);
        if (mismatches == 0 && pending_terms.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #80_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/cfe_pkg.sv
hw/rtl/cfe_ifs.sv
hw/rtl/cfe_divider.sv
hw/rtl/continued_fraction_expander.sv
tb/sv/testbench.sv
